/* hdl/fixed_slot_pool_allocator_unit_assert.svh */
// Assertion shorthands for the RTL. Each expects clk and rst_n in scope.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// The expression holds at every rising clock edge outside reset.
`define FSPA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define FSPA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/fspa_pkg.sv */
package fspa_pkg;

  localparam int MAX_SLOTS  = 256;
  localparam int MAX_BLOCKS = 8;
  localparam int SLOT_W     = 8;
  localparam int BLK_W      = 3;
  localparam int GIDX_W     = 11;
  localparam int TOTAL      = MAX_SLOTS * MAX_BLOCKS;
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 4;
  localparam int USED_W     = 12;
  localparam int SPB_W      = 9;
  localparam int SIZE_W     = 16;
  localparam int PROD_W     = 28;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam logic [SPB_W-1:0]  SPB_RESET  = 9'd256;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd64;
  localparam logic [ADDR_W-1:0] BASE_RESET = 32'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_SLOTS_PER_BLOCK = 2'd0,
    CFG_SLOT_SIZE       = 2'd1,
    CFG_POOL_BASE       = 2'd2
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_EXHAUSTED   = 3'd1,
    STAT_NULL        = 3'd2,
    STAT_MISALIGNED  = 3'd3,
    STAT_DOUBLE_FREE = 3'd4,
    STAT_OUTSIDE     = 3'd5,
    STAT_BAD_INDEX   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_QUERY,
    CMD_REPORT
  } cmd_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_WR,
    ST_ALLOC_ADD,
    ST_FREE_LIM1,
    ST_FREE_LIM2,
    ST_FREE_CMP,
    ST_FREE_DIV1,
    ST_FREE_DIV2,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_QUERY_DIV,
    ST_QUERY_RD,
    ST_QUERY_ANS,
    ST_EMIT
  } state_t;

  typedef struct packed {
    cmd_kind_t           kind;
    status_t             status;
    logic [ADDR_W-1:0]   diff;
    logic [GIDX_W-1:0]   slot_number;
  } cmd_t;

  typedef struct packed {
    logic [SPB_W-1:0]  n_eff;
    logic [SIZE_W-1:0] size_eff;
    logic [ADDR_W-1:0] base;
  } pool_cfg_t;

  typedef struct packed {
    logic              free;
    logic              ok;
    logic [SLOT_W-1:0] link;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0]  active_blocks;
    logic [USED_W-1:0] used_slots;
    logic              slot_is_free;
    logic [ADDR_W-1:0] slot_address;
    status_t           status;
  } result_t;

endpackage

/* hdl/fixed_slot_pool_allocator_unit.sv */
// Fixed-slot pool allocator with up to eight blocks of up to 256 slots each.
// Input channel in_*: one request per item (allocate, free by address, or
// query by global slot index). Output channel out_*: exactly one result item
// per request, in request order, carrying status, slot address, free flag,
// used slot count and active block count.
// Configuration channel cfg_*: always ready; a write to a known register
// resets the pool to one empty block. Write only while the block is idle.
// A free runs two divisions and a query one through a shared divider that
// yields one quotient bit per cycle; that divider takes most of the time of
// both. Items are worked one at a time: the engine takes no new request
// until the result of the last one is loaded into the result register.
// A two-entry queue in front accepts items while the engine is busy, and a
// result register lets the engine finish the next item while a result
// waits for out_tready; the engine holds while that register stays full.
// Reset (rst_n low, synchronous) restores the register defaults, one active
// block with every slot free, and empties queue and result register.
module fixed_slot_pool_allocator_unit import fspa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] operation, [33:2] free_address, [44:34] slot_number
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] status, [34:3] slot_address, [35] slot_is_free,
  // [47:36] used_slots, [51:48] active_blocks
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data
);

  logic [SPB_W-1:0]  spb_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] base_r;
  logic              cfg_wr, init_r;
  pool_cfg_t         pcfg;
  cmd_t              cmd;
  logic              cmd_valid, cmd_ready;
  result_t           result;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r  <= SPB_RESET;
      size_r <= SIZE_RESET;
      base_r <= BASE_RESET;
      init_r <= 1'b0;
    end else begin
      init_r <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SLOTS_PER_BLOCK: begin
            spb_r  <= cfg_data[SPB_W-1:0];
            init_r <= 1'b1;
          end
          CFG_SLOT_SIZE: begin
            size_r <= cfg_data[SIZE_W-1:0];
            init_r <= 1'b1;
          end
          CFG_POOL_BASE: begin
            base_r <= cfg_data;
            init_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Out-of-range settings clamp: zero slots acts as one, above the block
  // size acts as the block size, and zero slot size acts as one byte.
  always_comb begin
    if (spb_r == '0) begin
      pcfg.n_eff = SPB_W'(1);
    end else if (spb_r > SPB_W'(MAX_SLOTS)) begin
      pcfg.n_eff = SPB_W'(MAX_SLOTS);
    end else begin
      pcfg.n_eff = spb_r;
    end
    pcfg.size_eff = (size_r == '0) ? SIZE_W'(1) : size_r;
    pcfg.base     = base_r;
  end

  fspa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .pool_base      (base_r),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_operation   (in_tdata[OP_W-1:0]),
    .in_free_address(in_tdata[OP_W +: ADDR_W]),
    .in_slot_number (in_tdata[OP_W+ADDR_W +: GIDX_W]),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd)
  );

  fspa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .init      (init_r),
    .pcfg      (pcfg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .result    (result)
  );

  assign out_tdata = {(OUT_DATA_W - $bits(result_t))'(0), result};

endmodule

/* hdl/fspa_ram.sv */
module fspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/fspa_div.sv */
// Restoring divider, one quotient bit per cycle. The upper dividend part
// must be below the divisor, so the quotient fits in Q_W bits.
module fspa_div #(
  parameter int Q_W = 11,
  parameter int D_W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [D_W-1:0] hi,
  input  logic [Q_W-1:0] lo,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [Q_W-1:0] quo,
  output logic [D_W-1:0] rem
);

  localparam int CW = $clog2(Q_W + 1);

  logic           busy_r, done_r;
  logic [CW-1:0]  cnt_r;
  logic [D_W-1:0] rem_r, div_r, rem_nxt;
  logic [Q_W-1:0] quo_r, quo_nxt;
  logic [D_W:0]   trial;

  always_comb begin
    trial = {rem_r, quo_r[Q_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = D_W'(trial - {1'b0, div_r});
      quo_nxt = {quo_r[Q_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[D_W-1:0];
      quo_nxt = {quo_r[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      rem_r  <= hi;
      quo_r  <= lo;
      div_r  <= divisor;
      cnt_r  <= CW'(Q_W);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* hdl/fspa_front.sv */
// Decodes each request and parks it in a two-entry queue for the engine.
module fspa_front import fspa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] pool_base,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [ADDR_W-1:0] in_free_address,
  input  logic [GIDX_W-1:0] in_slot_number,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.diff        = in_free_address - pool_base;
    dec.slot_number = in_slot_number;
    dec.status      = STAT_OK;
    unique case (op_t'(in_operation))
      OP_ALLOC: dec.kind = CMD_ALLOC;
      OP_FREE: begin
        if (in_free_address == '0) begin
          dec.kind   = CMD_REPORT;
          dec.status = STAT_NULL;
        end else begin
          dec.kind = CMD_FREE;
        end
      end
      OP_QUERY: dec.kind = CMD_QUERY;
      default: begin
        dec.kind   = CMD_REPORT;
        dec.status = STAT_BAD_INDEX;
      end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        fifo_r[wr_ptr_r] <= dec;
        wr_ptr_r         <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hdl/fspa_back.sv */
`include "fixed_slot_pool_allocator_unit_assert.svh"

// Carries out one request at a time against the block lists and the slot RAM.
// Each block keeps a watermark: slots at or above it were never touched and
// read as free with their initial link, so no clearing pass is needed.
module fspa_back import fspa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      init,
  input  pool_cfg_t pcfg,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_tvalid,
  input  logic      out_tready,
  output result_t   result
);

  localparam int AW = $clog2(TOTAL);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [USED_W-1:0]  used_r, lin_r;
  logic [SLOT_W-1:0]  head_r [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] head_ok_r;
  logic [SPB_W-1:0]   mark_r [MAX_BLOCKS];
  logic [BLK_W-1:0]   blk_r, pick;
  logic [SLOT_W-1:0]  slot_r;
  logic [ADDR_W-1:0]  diff_r, saddr_r;
  logic [PROD_W-1:0]  prod_r;
  status_t            status_r;
  logic               sfree_r;
  logic               any_cand, can_grow, untouched;
  logic               out_valid_r, out_load;
  result_t            res_r;
  entry_t             rd_ent, ent, wdata;
  logic               ram_we;
  logic [AW-1:0]      raddr;
  logic               div_start, div_done;
  logic [SIZE_W-1:0]  div_hi, div_d, div_rem;
  logic [GIDX_W-1:0]  div_lo, div_quo;

  // First active block whose list is not empty.
  always_comb begin
    any_cand = 1'b0;
    pick     = '0;
    for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
      if (head_ok_r[b] && (CNT_W'(b) < count_r)) begin
        any_cand = 1'b1;
        pick     = BLK_W'(b);
      end
    end
  end

  assign can_grow  = count_r < CNT_W'(MAX_BLOCKS);
  assign untouched = {1'b0, slot_r} >= mark_r[blk_r];

  always_comb begin
    if (untouched) begin
      ent.free = 1'b1;
      ent.ok   = (SPB_W'(slot_r) + 1'b1) < pcfg.n_eff;
      ent.link = slot_r + 1'b1;
    end else begin
      ent = rd_ent;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_ALLOC:  state_nxt = (any_cand || can_grow) ? ST_ALLOC_RD : ST_EMIT;
            CMD_FREE:   state_nxt = ST_FREE_LIM1;
            CMD_QUERY:  state_nxt = ST_QUERY_DIV;
            default:    state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_ALLOC_RD:  state_nxt = ST_ALLOC_WR;
      ST_ALLOC_WR:  state_nxt = ST_ALLOC_ADD;
      ST_ALLOC_ADD: state_nxt = ST_EMIT;
      ST_FREE_LIM1: state_nxt = ST_FREE_LIM2;
      ST_FREE_LIM2: state_nxt = ST_FREE_CMP;
      ST_FREE_CMP:  state_nxt = (diff_r >= ADDR_W'(prod_r)) ? ST_EMIT : ST_FREE_DIV1;
      ST_FREE_DIV1: begin
        if (div_done) begin
          state_nxt = (div_rem != '0) ? ST_EMIT : ST_FREE_DIV2;
        end
      end
      ST_FREE_DIV2: begin
        if (div_done) begin
          state_nxt = ST_FREE_RD;
        end
      end
      ST_FREE_RD:   state_nxt = ST_FREE_WR;
      ST_FREE_WR:   state_nxt = ST_EMIT;
      ST_QUERY_DIV: begin
        if (div_done) begin
          state_nxt = (div_quo >= GIDX_W'(count_r)) ? ST_EMIT : ST_QUERY_RD;
        end
      end
      ST_QUERY_RD:  state_nxt = ST_QUERY_ANS;
      ST_QUERY_ANS: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state_r == ST_IDLE);
    out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
    raddr     = {blk_r, slot_r};
    ram_we    = 1'b0;
    wdata     = ent;
    div_start = 1'b0;
    div_hi    = '0;
    div_lo    = cmd.slot_number;
    div_d     = SIZE_W'(pcfg.n_eff);
    unique case (state_r)
      ST_IDLE: begin
        div_start = cmd_valid && (cmd.kind == CMD_QUERY);
      end
      ST_ALLOC_RD: begin
        raddr = {blk_r, head_r[blk_r]};
      end
      ST_ALLOC_WR: begin
        ram_we     = 1'b1;
        wdata.free = 1'b0;
      end
      ST_FREE_CMP: begin
        div_start = (diff_r < ADDR_W'(prod_r));
        div_hi    = diff_r[GIDX_W +: SIZE_W];
        div_lo    = diff_r[GIDX_W-1:0];
        div_d     = pcfg.size_eff;
      end
      ST_FREE_DIV1: begin
        div_start = div_done && (div_rem == '0);
        div_lo    = div_quo;
      end
      ST_FREE_WR: begin
        ram_we     = !ent.free;
        wdata.free = 1'b1;
        wdata.ok   = head_ok_r[blk_r];
        wdata.link = head_r[blk_r];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      state_r   <= ST_IDLE;
      count_r   <= CNT_W'(1);
      used_r    <= '0;
      head_ok_r <= '1;
      for (int b = 0; b < MAX_BLOCKS; b++) begin
        head_r[b] <= '0;
        mark_r[b] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            status_r <= cmd.status;
            diff_r   <= cmd.diff;
            saddr_r  <= '0;
            sfree_r  <= 1'b0;
            if (cmd.kind == CMD_ALLOC) begin
              if (any_cand) begin
                blk_r <= pick;
              end else if (can_grow) begin
                blk_r   <= count_r[BLK_W-1:0];
                count_r <= count_r + 1'b1;
              end else begin
                status_r <= STAT_EXHAUSTED;
              end
            end
          end
        end
        ST_ALLOC_RD: begin
          slot_r <= head_r[blk_r];
          lin_r  <= USED_W'(USED_W'(blk_r) * USED_W'(pcfg.n_eff))
                    + USED_W'(head_r[blk_r]);
        end
        ST_ALLOC_WR: begin
          head_r[blk_r]    <= ent.link;
          head_ok_r[blk_r] <= ent.ok;
          if (untouched) begin
            mark_r[blk_r] <= SPB_W'(slot_r) + 1'b1;
          end
          used_r <= used_r + 1'b1;
          prod_r <= PROD_W'(PROD_W'(lin_r) * PROD_W'(pcfg.size_eff));
        end
        ST_ALLOC_ADD: saddr_r <= pcfg.base + ADDR_W'(prod_r);
        ST_FREE_LIM1: lin_r <= USED_W'(USED_W'(count_r) * USED_W'(pcfg.n_eff));
        ST_FREE_LIM2: prod_r <= PROD_W'(PROD_W'(lin_r) * PROD_W'(pcfg.size_eff));
        ST_FREE_CMP: begin
          if (diff_r >= ADDR_W'(prod_r)) begin
            status_r <= STAT_OUTSIDE;
          end
        end
        ST_FREE_DIV1: begin
          if (div_done && (div_rem != '0)) begin
            status_r <= STAT_MISALIGNED;
          end
        end
        ST_FREE_DIV2: begin
          if (div_done) begin
            blk_r  <= div_quo[BLK_W-1:0];
            slot_r <= div_rem[SLOT_W-1:0];
          end
        end
        ST_FREE_WR: begin
          if (ent.free) begin
            status_r <= STAT_DOUBLE_FREE;
          end else begin
            head_r[blk_r]    <= slot_r;
            head_ok_r[blk_r] <= 1'b1;
            used_r           <= used_r - 1'b1;
          end
        end
        ST_QUERY_DIV: begin
          if (div_done) begin
            if (div_quo >= GIDX_W'(count_r)) begin
              status_r <= STAT_BAD_INDEX;
            end else begin
              blk_r  <= div_quo[BLK_W-1:0];
              slot_r <= div_rem[SLOT_W-1:0];
            end
          end
        end
        ST_QUERY_ANS: sfree_r <= ent.free;
        default: begin
        end
      endcase
    end
  end

  // Result register; while a result waits, the front still takes items until its queue is full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      res_r.status        <= status_r;
      res_r.slot_address  <= saddr_r;
      res_r.slot_is_free  <= sfree_r;
      res_r.used_slots    <= used_r;
      res_r.active_blocks <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign result     = res_r;

  fspa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TOTAL)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr({blk_r, slot_r}),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_ent)
  );

  fspa_div #(
    .Q_W(GIDX_W),
    .D_W(SIZE_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .hi     (div_hi),
    .lo     (div_lo),
    .divisor(div_d),
    .done   (div_done),
    .quo    (div_quo),
    .rem    (div_rem)
  );

  `FSPA_ASSERT_ALWAYS(a_count_range, (count_r != '0) && (count_r <= CNT_W'(MAX_BLOCKS)), "block count out of range")
  `FSPA_ASSERT_ALWAYS(a_used_bound, used_r <= USED_W'(USED_W'(count_r) * USED_W'(MAX_SLOTS)), "used slots exceed capacity")
  `FSPA_ASSERT_IMPLY(a_free_block, state_r == ST_FREE_WR, CNT_W'(blk_r) < count_r, "free targets inactive block")

endmodule

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fspa_pkg::*;

  typedef struct {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [GIDX_W-1:0]  slot_number;
  } request_t;

  typedef struct {
    op_t     op;
    result_t res;
  } outcome_t;

  typedef struct {
    cfg_reg_t          index;
    logic [ADDR_W-1:0] value;
  } reg_write_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [ADDR_W-1:0]     cfg_data = '0;

  fixed_slot_pool_allocator_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  request_t   request_q[$];
  reg_write_t reg_write_q[$];
  outcome_t   pending_results[$];
  logic [ADDR_W-1:0] granted_addrs[$];
  int  errors = 0;
  bit  calm = 1'b0;
  int  ready_holdoff = 0;

  // Shadow of the pool, updated as requests are accepted.
  logic [SPB_W-1:0]  spb_reg;
  logic [SIZE_W-1:0] size_reg;
  logic [ADDR_W-1:0] base_reg;
  int                blk_count;
  logic [8:0]        head[MAX_BLOCKS];
  bit                head_ok[MAX_BLOCKS];
  int                blk_used[MAX_BLOCKS];
  logic [8:0]        link[TOTAL];
  bit                link_ok[TOTAL];
  bit                slot_free[TOTAL];

  function automatic int slots_eff();
    if (spb_reg == 0) return 1;
    if (spb_reg > MAX_SLOTS) return MAX_SLOTS;
    return int'(spb_reg);
  endfunction

  function automatic void clear_block(int b);
    int n;
    n = slots_eff();
    head[b] = '0;
    head_ok[b] = 1'b1;
    blk_used[b] = 0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_free[b*MAX_SLOTS+i] = 1'b1;
      link[b*MAX_SLOTS+i] = 9'(i + 1);
      link_ok[b*MAX_SLOTS+i] = (i + 1 < n);
    end
  endfunction

  function automatic void clear_pool();
    blk_count = 1;
    for (int b = 0; b < MAX_BLOCKS; b++) clear_block(b);
  endfunction

  function automatic void write_reg(cfg_reg_t index, logic [ADDR_W-1:0] value);
    case (index)
      CFG_SLOTS_PER_BLOCK: spb_reg = value[SPB_W-1:0];
      CFG_SLOT_SIZE:       size_reg = value[SIZE_W-1:0];
      CFG_POOL_BASE:       base_reg = value;
      default:             return;
    endcase
    clear_pool();
  endfunction

  function automatic result_t serve_request(request_t r);
    result_t res;
    longint unsigned n, sz, span, diff, off;
    int s, g, b, k, total;
    bit done;
    res = '0;
    res.status = STAT_OK;
    n = slots_eff();
    sz = (size_reg == 0) ? 1 : size_reg;
    case (r.op)
      OP_ALLOC: begin
        done = 1'b0;
        for (b = 0; b < blk_count; b++) begin
          if (head_ok[b]) begin
            s = head[b] % MAX_SLOTS;
            g = b * MAX_SLOTS + s;
            slot_free[g] = 1'b0;
            head_ok[b] = link_ok[g];
            head[b] = link[g];
            blk_used[b]++;
            res.slot_address = base_reg + ADDR_W'((b * n + s) * sz);
            done = 1'b1;
            break;
          end
          if (b + 1 == blk_count && blk_count < MAX_BLOCKS) begin
            blk_count++;
            clear_block(blk_count - 1);
          end
        end
        if (!done) res.status = STAT_EXHAUSTED;
      end
      OP_FREE: begin
        span = n * sz;
        diff = 32'(r.addr - base_reg);
        if (r.addr == 0) res.status = STAT_NULL;
        else if (diff >= span * blk_count) res.status = STAT_OUTSIDE;
        else begin
          off = diff % span;
          b = int'(diff / span);
          if (off % sz != 0) res.status = STAT_MISALIGNED;
          else begin
            s = int'(off / sz);
            g = b * MAX_SLOTS + s;
            if (slot_free[g]) res.status = STAT_DOUBLE_FREE;
            else begin
              slot_free[g] = 1'b1;
              link[g] = head[b];
              link_ok[g] = head_ok[b];
              head[b] = 9'(s);
              head_ok[b] = 1'b1;
              blk_used[b]--;
            end
          end
        end
      end
      OP_QUERY: begin
        k = int'(r.slot_number) / int'(n);
        if (k >= blk_count) res.status = STAT_BAD_INDEX;
        else res.slot_is_free = slot_free[k*MAX_SLOTS + int'(r.slot_number) % int'(n)];
      end
      default: res.status = STAT_BAD_INDEX;
    endcase
    total = 0;
    for (b = 0; b < blk_count; b++) total += blk_used[b];
    res.used_slots = USED_W'(total);
    res.active_blocks = CNT_W'(blk_count);
    return res;
  endfunction

  initial begin
    spb_reg = SPB_RESET;
    size_reg = SIZE_RESET;
    base_reg = BASE_RESET;
    clear_pool();
  end

  // Driver: request channel and register writes.
  always @(posedge clk) begin
    request_t r;
    reg_write_t w;
    outcome_t o;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_tvalid && in_tready) begin
        r.op = op_t'(in_tdata[1:0]);
        r.addr = in_tdata[33:2];
        r.slot_number = in_tdata[44:34];
        o.op = r.op;
        o.res = serve_request(r);
        pending_results.insert(pending_results.size(), o);
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_write_q.size() > 0) begin
          w = reg_write_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.index;
          cfg_data <= w.value;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (request_q.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
          r = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {3'b000, r.slot_number, r.addr, r.op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and drives out_tready.
  always @(posedge clk) begin
    result_t got;
    outcome_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[51:0]);
        if (pending_results.size() == 0) begin
          $error("result item with none expected: %h", out_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.res.status) begin
            $error("status: expected %0d, got %0d", want.res.status, got.status);
            errors++;
          end
          if (got.slot_address !== want.res.slot_address) begin
            $error("slot_address: expected %h, got %h", want.res.slot_address,
                   got.slot_address);
            errors++;
          end
          if (got.slot_is_free !== want.res.slot_is_free) begin
            $error("slot_is_free: expected %0d, got %0d", want.res.slot_is_free,
                   got.slot_is_free);
            errors++;
          end
          if (got.used_slots !== want.res.used_slots) begin
            $error("used_slots: expected %0d, got %0d", want.res.used_slots,
                   got.used_slots);
            errors++;
          end
          if (got.active_blocks !== want.res.active_blocks) begin
            $error("active_blocks: expected %0d, got %0d", want.res.active_blocks,
                   got.active_blocks);
            errors++;
          end
          if (want.op == OP_ALLOC && want.res.status == STAT_OK)
            granted_addrs.insert(granted_addrs.size(), want.res.slot_address);
        end
      end
      if (ready_holdoff > 0) begin
        ready_holdoff--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 28);
      end
    end
  end

  task automatic send(op_t op, logic [ADDR_W-1:0] addr, logic [GIDX_W-1:0] slot_number);
    request_t r;
    r.op = op;
    r.addr = addr;
    r.slot_number = slot_number;
    while (request_q.size() >= 4) @(posedge clk);
    request_q.insert(request_q.size(), r);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (request_q.size() > 0 || in_tvalid || pending_results.size() > 0);
  endtask

  // The pause before a write keeps it clear of the last request.
  task automatic set_pool(logic [ADDR_W-1:0] spb, logic [ADDR_W-1:0] size,
                          logic [ADDR_W-1:0] base);
    reg_write_t w;
    drain();
    repeat (40) @(posedge clk);
    w.index = CFG_SLOTS_PER_BLOCK; w.value = spb;  reg_write_q.insert(reg_write_q.size(), w);
    w.index = CFG_SLOT_SIZE;       w.value = size; reg_write_q.insert(reg_write_q.size(), w);
    w.index = CFG_POOL_BASE;       w.value = base; reg_write_q.insert(reg_write_q.size(), w);
    do @(posedge clk); while (reg_write_q.size() > 0 || cfg_valid);
    granted_addrs.delete();
  endtask

  task automatic random_item(int n_slots, int size);
    int pick, idx;
    logic [ADDR_W-1:0] a;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send(OP_ALLOC, $urandom, GIDX_W'($urandom));
    end else if (pick < 85) begin
      if (granted_addrs.size() > 0 && $urandom_range(9) < 8) begin
        idx = $urandom_range(granted_addrs.size() - 1);
        a = granted_addrs[idx];
        granted_addrs.delete(idx);
        // Now and then re-free the same slot or hit its interior.
        if ($urandom_range(9) == 0) granted_addrs.insert(granted_addrs.size(), a);
        if (size > 1 && $urandom_range(19) == 0) a = a + $urandom_range(size - 1, 1);
      end else begin
        a = $urandom;
      end
      send(OP_FREE, a, GIDX_W'($urandom));
    end else if (pick < 97) begin
      if ($urandom_range(3) == 0) send(OP_QUERY, $urandom, GIDX_W'($urandom));
      else send(OP_QUERY, $urandom, GIDX_W'($urandom_range(MAX_BLOCKS * n_slots - 1)));
    end else begin
      send(OP_NONE, $urandom, GIDX_W'($urandom));
    end
  endtask

  initial begin
    int spb, size, n_eff, size_eff;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults: the basic requests and every error status but exhausted.
    send(OP_QUERY, 0, 0);
    send(OP_ALLOC, 0, 0);
    send(OP_ALLOC, 32'hFFFF_FFFF, 11'h7FF);
    send(OP_QUERY, 0, 1);
    send(OP_FREE, 32'd4160, 0);
    send(OP_FREE, 32'd4160, 0);
    send(OP_FREE, 32'd0, 0);
    send(OP_FREE, 32'd4097, 0);
    send(OP_FREE, 32'd4095, 0);
    send(OP_FREE, 32'hFFFF_FFFF, 0);
    send(OP_QUERY, 0, 11'd2047);
    send(OP_QUERY, 0, 11'd255);
    send(OP_NONE, 32'hFFFF_FFFF, 11'h7FF);

    // Zero pool base and zero-valued registers: one-slot blocks until exhausted.
    set_pool(0, 0, 0);
    repeat (10) send(OP_ALLOC, 0, 0);
    send(OP_FREE, 0, 0);
    send(OP_QUERY, 0, 7);
    send(OP_QUERY, 0, 8);
    send(OP_FREE, 1, 0);
    send(OP_ALLOC, 0, 0);

    // Oversized slot count, largest slot, base at the top so addresses wrap.
    set_pool(511, 65535, 32'hFFFF_FFFF);
    send(OP_ALLOC, 0, 0);
    send(OP_ALLOC, 0, 0);
    send(OP_FREE, 32'h0000_FFFE, 0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin spb = 3;   size = 16;    set_pool(spb, size, 32'h0000_1000); end
        1: begin spb = 1;   size = 1;     set_pool(spb, size, 32'hFFFF_FFF0); end
        2: begin spb = 256; size = 65535; set_pool(spb, size, 32'h8000_0000); end
        3: begin spb = 0;   size = 0;     set_pool(spb, size, 0); end
        default: begin
          spb = $urandom_range(24, 1);
          size = $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(200, 1);
          set_pool(spb, size, $urandom);
        end
      endcase
      n_eff = (spb == 0) ? 1 : (spb > MAX_SLOTS ? MAX_SLOTS : spb);
      size_eff = (size == 0) ? 1 : size;
      calm = (ph == 2);
      for (int i = 0; i < 220; i++) begin
        if (ph == 3 && i == 60) ready_holdoff = 300;
        if (ph == 4 && i == 100) drain();
        random_item(n_eff, size_eff);
      end
    end
    calm = 1'b0;
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/fspa_pkg.sv
hdl/fspa_ram.sv
hdl/fspa_div.sv
hdl/fspa_front.sv
hdl/fspa_back.sv
hdl/fixed_slot_pool_allocator_unit.sv
tb/sv/testbench.sv
